// ===== design/efhs_pkg.sv =====
// Shared constants and beat payload types for the ECMP flow hash selector.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package efhs_pkg;

   localparam int HASH_W        = 32;
   localparam int KEY_WORDS     = 3;
   localparam int KEY_W         = KEY_WORDS * HASH_W;
   localparam int PROTO_W       = 8;
   localparam int PORT_W        = 16;
   localparam int COUNT_W       = 7;
   localparam int SLOT_W        = 6;

   localparam int MAX_NEXT_HOPS_DEFAULT = 64;

   localparam int MOD_STEP_BITS = 4;
   localparam int MOD_CELLS     = HASH_W / MOD_STEP_BITS;

   localparam logic [HASH_W-1:0] MM_C1     = 32'hcc9e2d51;
   localparam logic [HASH_W-1:0] MM_C2     = 32'h1b873593;
   localparam logic [HASH_W-1:0] MM_N      = 32'he6546b64;
   localparam logic [HASH_W-1:0] MM_F1     = 32'h85ebca6b;
   localparam logic [HASH_W-1:0] MM_F2     = 32'hc2b2ae35;
   localparam logic [HASH_W-1:0] KEY_BYTES = 32'd12;

   localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'h06;
   localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'h11;
   localparam logic [PROTO_W-1:0] PROTO_ACK  = 8'hFC;
   localparam logic [PROTO_W-1:0] PROTO_NACK = 8'hFD;

   typedef struct packed {
      logic [HASH_W-1:0]  source_addr;
      logic [HASH_W-1:0]  dest_addr;
      logic [PROTO_W-1:0] protocol;
      logic [PORT_W-1:0]  source_port;
      logic [PORT_W-1:0]  dest_port;
      logic [COUNT_W-1:0] next_hop_count;
   } req_payload_type;

   typedef struct packed {
      logic [HASH_W-1:0] flow_hash;
      logic [SLOT_W-1:0] hop_slot;
      logic              route_found;
   } rsp_payload_type;

endpackage

// ===== design/efhs_stream_if.sv =====
// Valid/ready stream channel carrying one beat of a given payload type.
// Payload types come from efhs_pkg.
`timescale 1ns / 1ps

interface efhs_stream_if #(
   parameter type payload_type = efhs_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/efhs_mix_cell.sv =====
// One murmur3 body round as a three-stage cell: multiply, multiply, mix into state.
// Consumes the low key word and hands the rest of the key on. Uses efhs_pkg.
`timescale 1ns / 1ps

module efhs_mix_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [efhs_pkg::HASH_W-1:0]   in_hash,
   input  logic [efhs_pkg::KEY_W-1:0]    in_key,
   input  logic [efhs_pkg::COUNT_W-1:0]  in_count,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [efhs_pkg::HASH_W-1:0]   out_hash,
   output logic [efhs_pkg::KEY_W-1:0]    out_key,
   output logic [efhs_pkg::COUNT_W-1:0]  out_count
);

   localparam int HW = efhs_pkg::HASH_W;
   localparam int KW = efhs_pkg::KEY_W;

   logic [2:0]                      valid_ff;
   logic [2:0]                      rdy;
   logic [HW-1:0]                   h_ff     [3];
   logic [KW-1:0]                   key_ff   [3];
   logic [efhs_pkg::COUNT_W-1:0]    count_ff [3];
   logic [HW-1:0]                   k1_ff;
   logic [HW-1:0]                   k2_ff;
   logic [HW-1:0]                   k1_in;
   logic [HW-1:0]                   k2_in;
   logic [HW-1:0]                   h_in;
   logic [HW-1:0]                   mixed;
   logic [HW-1:0]                   rotated;

   assign rdy[2]   = !valid_ff[2] || out_ready;
   assign rdy[1]   = !valid_ff[1] || rdy[2];
   assign rdy[0]   = !valid_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_comb begin
      k1_in   = in_key[HW-1:0] * efhs_pkg::MM_C1;
      k2_in   = {k1_ff[HW-16:0], k1_ff[HW-1:HW-15]} * efhs_pkg::MM_C2;
      mixed   = h_ff[1] ^ k2_ff;
      rotated = {mixed[HW-14:0], mixed[HW-1:HW-13]};
      h_in    = rotated + {rotated[HW-3:0], 2'b00} + efhs_pkg::MM_N;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
      if (rdy[0] && in_valid) begin
         h_ff[0]     <= in_hash;
         k1_ff       <= k1_in;
         key_ff[0]   <= {{HW{1'b0}}, in_key[KW-1:HW]};
         count_ff[0] <= in_count;
      end
      if (rdy[1] && valid_ff[0]) begin
         h_ff[1]     <= h_ff[0];
         k2_ff       <= k2_in;
         key_ff[1]   <= key_ff[0];
         count_ff[1] <= count_ff[0];
      end
      if (rdy[2] && valid_ff[1]) begin
         h_ff[2]     <= h_in;
         key_ff[2]   <= key_ff[1];
         count_ff[2] <= count_ff[1];
      end
   end

   assign out_valid = valid_ff[2];
   assign out_hash  = h_ff[2];
   assign out_key   = key_ff[2];
   assign out_count = count_ff[2];

endmodule

// ===== design/efhs_fmix.sv =====
// murmur3 length fold and final avalanche in two multiply stages.
// Uses efhs_pkg constants.
`timescale 1ns / 1ps

module efhs_fmix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [efhs_pkg::HASH_W-1:0]   in_hash,
   input  logic [efhs_pkg::COUNT_W-1:0]  in_count,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [efhs_pkg::HASH_W-1:0]   out_hash,
   output logic [efhs_pkg::COUNT_W-1:0]  out_count
);

   localparam int HW = efhs_pkg::HASH_W;

   logic [1:0]                      valid_ff;
   logic [1:0]                      rdy;
   logic [HW-1:0]                   p1_ff;
   logic [HW-1:0]                   p2_ff;
   logic [efhs_pkg::COUNT_W-1:0]    count_ff [2];
   logic [HW-1:0]                   x;
   logic [HW-1:0]                   y;
   logic [HW-1:0]                   p1_in;
   logic [HW-1:0]                   p2_in;

   assign rdy[1]   = !valid_ff[1] || out_ready;
   assign rdy[0]   = !valid_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_comb begin
      x     = in_hash ^ efhs_pkg::KEY_BYTES;
      x     = x ^ (x >> 16);
      p1_in = x * efhs_pkg::MM_F1;
      y     = p1_ff ^ (p1_ff >> 13);
      p2_in = y * efhs_pkg::MM_F2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
      end
      if (rdy[0] && in_valid) begin
         p1_ff       <= p1_in;
         count_ff[0] <= in_count;
      end
      if (rdy[1] && valid_ff[0]) begin
         p2_ff       <= p2_in;
         count_ff[1] <= count_ff[0];
      end
   end

   assign out_valid = valid_ff[1];
   assign out_hash  = p2_ff ^ (p2_ff >> 16);
   assign out_count = count_ff[1];

endmodule

// ===== design/efhs_mod_cell.sv =====
// Remainder cell: restoring division over a few hash bits per stage.
// A row of these yields hash modulo divisor. Uses efhs_pkg.
`timescale 1ns / 1ps

module efhs_mod_cell #(
   parameter int DIV_W    = 7,
   parameter int CELL_IDX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [efhs_pkg::HASH_W-1:0]  in_hash,
   input  logic [DIV_W-1:0]             in_rem,
   input  logic [DIV_W-1:0]             in_div,
   input  logic                         in_found,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [efhs_pkg::HASH_W-1:0]  out_hash,
   output logic [DIV_W-1:0]             out_rem,
   output logic [DIV_W-1:0]             out_div,
   output logic                         out_found
);

   localparam int STEP    = efhs_pkg::MOD_STEP_BITS;
   localparam int TOP_BIT = efhs_pkg::HASH_W - 1 - CELL_IDX * STEP;

   logic                         valid_ff;
   logic [efhs_pkg::HASH_W-1:0]  hash_ff;
   logic [DIV_W-1:0]             rem_ff;
   logic [DIV_W-1:0]             div_ff;
   logic                         found_ff;
   logic [DIV_W-1:0]             rem_in;
   logic [DIV_W:0]               wide;
   logic [STEP-1:0]              bits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      bits   = in_hash[TOP_BIT -: STEP];
      rem_in = in_rem;
      wide   = '0;
      for (int s = 0; s < STEP; s++) begin
         wide = {rem_in, bits[STEP-1-s]};
         if (wide >= {1'b0, in_div}) begin
            wide = wide - {1'b0, in_div};
         end
         rem_in = wide[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         hash_ff  <= in_hash;
         rem_ff   <= rem_in;
         div_ff   <= in_div;
         found_ff <= in_found;
      end
   end

   assign out_valid = valid_ff;
   assign out_hash  = hash_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_found = found_ff;

endmodule

// ===== design/ecmp_flow_hash_select_unit.sv =====
// Top level: seeded murmur3 flow hash and next-hop slot selection.
// Builds on efhs_pkg, efhs_stream_if, efhs_mix_cell, efhs_fmix, efhs_mod_cell.
//
//   channel   dir  beat content
//   req_if    in   source/dest address, protocol, ports, next-hop count
//   rsp_if    out  flow hash, hop slot, route found
//   csr_*     in   hash seed write, no read-back
//
// One beat per cycle sustained while rsp_if.ready holds; three 3-stage body cells,
// a 2-stage final mix, eight 4-bit remainder cells. The multiplier stages set the clock.
// Every stage holds when its successor is full and stalled; bubbles collapse.
// Synchronous reset clears all stage valids and the seed to zero.
`timescale 1ns / 1ps

module ecmp_flow_hash_select_unit #(
   parameter int MAX_NEXT_HOPS = efhs_pkg::MAX_NEXT_HOPS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [efhs_pkg::HASH_W-1:0]  csr_wr_data,
   efhs_stream_if.sink                  req_if,
   efhs_stream_if.source                rsp_if
);

   localparam int HW    = efhs_pkg::HASH_W;
   localparam int KW    = efhs_pkg::KEY_W;
   localparam int CW    = efhs_pkg::COUNT_W;
   localparam int NW    = efhs_pkg::KEY_WORDS;
   localparam int NC    = efhs_pkg::MOD_CELLS;
   localparam int DIV_W = $clog2(MAX_NEXT_HOPS + 1);

   logic [HW-1:0]     hash_seed_ff;
   logic [HW-1:0]     port_word;
   logic [KW-1:0]     key;

   logic              mix_valid [NW+1];
   logic              mix_ready [NW+1];
   logic [HW-1:0]     mix_hash  [NW+1];
   logic [KW-1:0]     mix_key   [NW+1];
   logic [CW-1:0]     mix_count [NW+1];

   logic              fm_valid;
   logic              fm_ready;
   logic [HW-1:0]     fm_hash;
   logic [CW-1:0]     fm_count;

   logic              md_valid [NC+1];
   logic              md_ready [NC+1];
   logic [HW-1:0]     md_hash  [NC+1];
   logic [DIV_W-1:0]  md_rem   [NC+1];
   logic [DIV_W-1:0]  md_div   [NC+1];
   logic              md_found [NC+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff <= '0;
      end else if (csr_wr_en) begin
         hash_seed_ff <= csr_wr_data;
      end
   end

   always_comb begin
      port_word = '0;
      if (req_if.payload.protocol inside {efhs_pkg::PROTO_TCP, efhs_pkg::PROTO_UDP,
                                          efhs_pkg::PROTO_ACK, efhs_pkg::PROTO_NACK}) begin
         port_word = {req_if.payload.dest_port, req_if.payload.source_port};
      end
      key = {port_word, req_if.payload.dest_addr, req_if.payload.source_addr};
   end

   assign mix_valid[0] = req_if.valid;
   assign req_if.ready = mix_ready[0];
   assign mix_hash[0]  = hash_seed_ff;
   assign mix_key[0]   = key;
   assign mix_count[0] = req_if.payload.next_hop_count;

   for (genvar i = 0; i < NW; i++) begin : g_mix
      efhs_mix_cell u_mix (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (mix_valid[i]),
         .in_ready  (mix_ready[i]),
         .in_hash   (mix_hash[i]),
         .in_key    (mix_key[i]),
         .in_count  (mix_count[i]),
         .out_valid (mix_valid[i+1]),
         .out_ready (mix_ready[i+1]),
         .out_hash  (mix_hash[i+1]),
         .out_key   (mix_key[i+1]),
         .out_count (mix_count[i+1])
      );
   end

   efhs_fmix u_fmix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid[NW]),
      .in_ready  (mix_ready[NW]),
      .in_hash   (mix_hash[NW]),
      .in_count  (mix_count[NW]),
      .out_valid (fm_valid),
      .out_ready (fm_ready),
      .out_hash  (fm_hash),
      .out_count (fm_count)
   );

   assign md_valid[0] = fm_valid;
   assign fm_ready    = md_ready[0];
   assign md_hash[0]  = fm_hash;
   assign md_rem[0]   = '0;
   assign md_div[0]   = (32'(fm_count) > 32'(MAX_NEXT_HOPS)) ? DIV_W'(MAX_NEXT_HOPS)
                                                            : DIV_W'(fm_count);
   assign md_found[0] = (fm_count != '0);

   for (genvar j = 0; j < NC; j++) begin : g_mod
      efhs_mod_cell #(
         .DIV_W    (DIV_W),
         .CELL_IDX (j)
      ) u_mod (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (md_valid[j]),
         .in_ready  (md_ready[j]),
         .in_hash   (md_hash[j]),
         .in_rem    (md_rem[j]),
         .in_div    (md_div[j]),
         .in_found  (md_found[j]),
         .out_valid (md_valid[j+1]),
         .out_ready (md_ready[j+1]),
         .out_hash  (md_hash[j+1]),
         .out_rem   (md_rem[j+1]),
         .out_div   (md_div[j+1]),
         .out_found (md_found[j+1])
      );
   end

   assign rsp_if.valid               = md_valid[NC];
   assign md_ready[NC]               = rsp_if.ready;
   assign rsp_if.payload.flow_hash   = md_hash[NC];
   assign rsp_if.payload.hop_slot    = md_found[NC] ? efhs_pkg::SLOT_W'(md_rem[NC]) : '0;
   assign rsp_if.payload.route_found = md_found[NC];

endmodule
